@@ src/jsma_pkg.sv @@
// Shared constants and types for the joint speed moving average unit.
package jsma_pkg;

  // Width of every sample, position, step and target (signed Q5.12).
  localparam int SAMP_W = 18;

  // Number of joint fields carried on the ports.
  localparam int NFIELDS = 6;

  // Default configuration.
  localparam int WINDOW_DEF = 50;
  localparam int JOINTS_DEF = 6;

  // Extra divisor applied on top of the window length.
  localparam int SCALE = 10;

  // Magnitude width of a quotient: |sum| / (WINDOW*10) never exceeds 13108.
  localparam int QUOT_W = 15;

  // Request type codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Saturation limits of the output range.
  localparam logic signed [SAMP_W-1:0] VAL_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] VAL_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

  // Control from the top level to each joint lane.
  typedef struct packed {
    logic sample_en;
    logic pipe_en;
  } lane_ctrl_t;

endpackage

@@ src/jsma_cell.sv @@
// One history cell: holds one speed sample of every joint and hands it on.
module jsma_cell
  import jsma_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic [JOINTS-1:0][SAMP_W-1:0]  d_in,
  output logic [JOINTS-1:0][SAMP_W-1:0]  d_out
);

  logic [JOINTS-1:0][SAMP_W-1:0] data_r;

  // The history starts cleared, so the cell resets to zero speed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

@@ src/jsma_lane.sv @@
// One joint lane: running window sum, divide by WINDOW*10 and saturated target.
module jsma_lane
  import jsma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctrl_t               ctrl,
  input  logic signed [SAMP_W-1:0] new_sample,
  input  logic signed [SAMP_W-1:0] old_sample,
  input  logic signed [SAMP_W-1:0] position,
  output logic signed [SAMP_W-1:0] step,
  output logic signed [SAMP_W-1:0] target
);

  // The sum holds WINDOW full-scale samples exactly.
  localparam int SUM_W   = SAMP_W + $clog2(WINDOW);
  localparam int DIV     = WINDOW * SCALE;
  localparam int DIV_W   = $clog2(DIV);
  // Exact reciprocal: floor(n*RECIP >> SHIFT) equals floor(n/DIV) for n < 2**SUM_W.
  localparam int SHIFT   = SUM_W + DIV_W;
  localparam int RECIP_W = SUM_W + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]         mag;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_a_r;
  logic signed [SAMP_W-1:0] pos_a_r;
  logic signed [SAMP_W-1:0] step_b_r, step_b_nxt;
  logic signed [SAMP_W-1:0] pos_b_r;
  logic [QUOT_W-1:0]        quot;
  logic signed [SAMP_W:0]   tsum;
  logic signed [SAMP_W-1:0] step_r;
  logic signed [SAMP_W-1:0] target_r, target_nxt;

  // Running sum: drop the oldest sample and add the new one.
  assign sum_nxt = sum_r
                 - {{(SUM_W-SAMP_W){old_sample[SAMP_W-1]}}, old_sample}
                 + {{(SUM_W-SAMP_W){new_sample[SAMP_W-1]}}, new_sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.sample_en) begin
      sum_r <= sum_nxt;
    end
  end

  // Magnitude of the sum; the most negative value maps to its unsigned magnitude.
  assign mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // Quotient magnitude and sign restore.
  assign quot       = prod_r[SHIFT +: QUOT_W];
  assign step_b_nxt = neg_a_r ? -$signed({{(SAMP_W-QUOT_W){1'b0}}, quot})
                              :  $signed({{(SAMP_W-QUOT_W){1'b0}}, quot});

  // Target with saturation to the field range.
  assign tsum = {pos_b_r[SAMP_W-1], pos_b_r} + {step_b_r[SAMP_W-1], step_b_r};

  always_comb begin
    if (tsum[SAMP_W] != tsum[SAMP_W-1]) begin
      target_nxt = tsum[SAMP_W] ? VAL_MIN : VAL_MAX;
    end else begin
      target_nxt = tsum[SAMP_W-1:0];
    end
  end

  // Three payload stages: reciprocal product, signed step, output register.
  always_ff @(posedge clk) begin
    if (ctrl.pipe_en) begin
      prod_r   <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_a_r  <= sum_r[SUM_W-1];
      pos_a_r  <= position;
      step_b_r <= step_b_nxt;
      pos_b_r  <= pos_a_r;
      step_r   <= step_b_r;
      target_r <= target_nxt;
    end
  end

  assign step   = step_r;
  assign target = target_r;

endmodule

@@ src/joint_speed_moving_average_unit.sv @@
// Top level of the joint speed moving average unit: history chain, lanes and control.
// A sample transaction (req_type 0) shifts the new speeds into a chain of WINDOW history
// cells and updates one running sum per joint in the same cycle; it gives no result and is
// accepted in every cycle, even while a result is held back. A tick transaction (req_type 1)
// is accepted once per cycle and its result passes through the reciprocal multiply, sign
// restore and saturating add stages of each joint lane; ticks are stalled only while the
// output register holds a result that is not taken. Reset clears the whole history at
// once, so no clearing pass is needed.
module joint_speed_moving_average_unit
  import jsma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic signed [SAMP_W-1:0] in_joint_0,
  input  logic signed [SAMP_W-1:0] in_joint_1,
  input  logic signed [SAMP_W-1:0] in_joint_2,
  input  logic signed [SAMP_W-1:0] in_joint_3,
  input  logic signed [SAMP_W-1:0] in_joint_4,
  input  logic signed [SAMP_W-1:0] in_joint_5,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SAMP_W-1:0] out_step_0,
  output logic signed [SAMP_W-1:0] out_step_1,
  output logic signed [SAMP_W-1:0] out_step_2,
  output logic signed [SAMP_W-1:0] out_step_3,
  output logic signed [SAMP_W-1:0] out_step_4,
  output logic signed [SAMP_W-1:0] out_step_5,
  output logic signed [SAMP_W-1:0] out_target_0,
  output logic signed [SAMP_W-1:0] out_target_1,
  output logic signed [SAMP_W-1:0] out_target_2,
  output logic signed [SAMP_W-1:0] out_target_3,
  output logic signed [SAMP_W-1:0] out_target_4,
  output logic signed [SAMP_W-1:0] out_target_5
);

  logic [NFIELDS-1:0][SAMP_W-1:0] in_vec;
  logic [JOINTS-1:0][SAMP_W-1:0]  chain [WINDOW+1];
  logic [NFIELDS-1:0][SAMP_W-1:0] step_w;
  logic [NFIELDS-1:0][SAMP_W-1:0] target_w;
  logic       hold;
  logic       sample_acc;
  logic       tick_acc;
  logic       a_v_r;
  logic       b_v_r;
  logic       out_valid_r;
  lane_ctrl_t ctrl;

  assign in_vec = {in_joint_5, in_joint_4, in_joint_3, in_joint_2, in_joint_1, in_joint_0};

  // Handshake: only a held result blocks, and only tick transactions.
  assign hold       = out_valid_r & out_stall;
  assign in_stall   = (in_req_type == REQ_TICK) & hold;
  assign sample_acc = in_valid & (in_req_type == REQ_SAMPLE);
  assign tick_acc   = in_valid & (in_req_type == REQ_TICK) & ~hold;

  assign ctrl.sample_en = sample_acc;
  assign ctrl.pipe_en   = ~hold;

  // Valid bits of the result pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (!hold) begin
      a_v_r       <= tick_acc;
      b_v_r       <= a_v_r;
      out_valid_r <= b_v_r;
    end
  end

  assign out_valid = out_valid_r;

  // History chain: cell 0 takes the new sample, the last cell holds the oldest.
  assign chain[0] = in_vec[JOINTS-1:0];

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    jsma_cell #(
      .JOINTS (JOINTS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (sample_acc),
      .d_in     (chain[k]),
      .d_out    (chain[k+1])
    );
  end

  // Joint lanes; fields beyond JOINTS read as zero.
  for (genvar j = 0; j < NFIELDS; j++) begin : g_lane
    if (j < JOINTS) begin : g_used
      jsma_lane #(
        .WINDOW (WINDOW)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_sample (in_vec[j]),
        .old_sample (chain[WINDOW][j]),
        .position   (in_vec[j]),
        .step       (step_w[j]),
        .target     (target_w[j])
      );
    end else begin : g_unused
      assign step_w[j]   = '0;
      assign target_w[j] = '0;
    end
  end

  assign out_step_0   = step_w[0];
  assign out_step_1   = step_w[1];
  assign out_step_2   = step_w[2];
  assign out_step_3   = step_w[3];
  assign out_step_4   = step_w[4];
  assign out_step_5   = step_w[5];
  assign out_target_0 = target_w[0];
  assign out_target_1 = target_w[1];
  assign out_target_2 = target_w[2];
  assign out_target_3 = target_w[3];
  assign out_target_4 = target_w[4];
  assign out_target_5 = target_w[5];

endmodule

@@ src/jsma_checker.sv @@
// Port-level assertions for the joint speed moving average unit, bound to the top level.
module jsma_checker
  import jsma_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     in_req_type,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [SAMP_W-1:0] out_step_0,
  input logic signed [SAMP_W-1:0] out_target_0
);

  // A stalled result holds its valid and the joint 0 step and target.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_0) && $stable(out_target_0))
    else $error("stalled result changed");

  // Sample transactions are never stalled.
  a_sample_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_req_type == REQ_TICK)
    else $error("sample transaction stalled");

  // Input stall only comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // The joint 0 step never leaves the range of the averaged speed.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_0 <= 18'sd13108) && (out_step_0 >= -18'sd13108))
    else $error("step out of range");

endmodule

bind joint_speed_moving_average_unit jsma_checker u_jsma_checker (.*);
